### src/safg_pkg.sv
// Shared constants, codes and lookup tables for the SNP allele fraction genotyper.
package safg_pkg;

    localparam int FRAC_BITS_DEF   = 16;
    localparam int BEAD_COUNT_DEF  = 40;
    localparam int SIGNAL_BITS_DEF = 16;

    localparam int TABLE_LAST = 40;
    localparam int K_W        = 6;
    localparam int SCORE_W    = 8;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_RS_FILTER      = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PASS_THRESHOLD = 1'd1;

    localparam logic [SCORE_W-1:0] PASS_THRESHOLD_RST = 8'd20;

    localparam logic [1:0] KIND_REF = 2'd0;
    localparam logic [1:0] KIND_ALT = 2'd1;
    localparam logic [1:0] KIND_CSW = 2'd2;

    localparam logic [1:0] COLOR_GREEN = 2'd0;
    localparam logic [1:0] COLOR_RED   = 2'd1;

    localparam logic [1:0] GT_HOM_REF = 2'd0;
    localparam logic [1:0] GT_HET     = 2'd1;
    localparam logic [1:0] GT_HOM_ALT = 2'd2;

    // Genotype per bead count: hom ref up to 10, het 11..29, hom alt from 30.
    function automatic logic [1:0] gt_lookup(input logic [K_W-1:0] k);
        logic [1:0] gt;
        if (k <= K_W'(10)) begin
            gt = GT_HOM_REF;
        end
        else if (k <= K_W'(29)) begin
            gt = GT_HET;
        end
        else begin
            gt = GT_HOM_ALT;
        end
        return gt;
    endfunction

    function automatic logic [SCORE_W-1:0] score_lookup(input logic [K_W-1:0] k);
        logic [SCORE_W-1:0] s;
        case (k)
            6'd0:    s = 8'd102;
            6'd1:    s = 8'd92;
            6'd2:    s = 8'd83;
            6'd3:    s = 8'd73;
            6'd4:    s = 8'd63;
            6'd5:    s = 8'd54;
            6'd6:    s = 8'd44;
            6'd7:    s = 8'd35;
            6'd8:    s = 8'd25;
            6'd9:    s = 8'd16;
            6'd10:   s = 8'd7;
            6'd11:   s = 8'd4;
            6'd12:   s = 8'd12;
            6'd13:   s = 8'd21;
            6'd14:   s = 8'd31;
            6'd15:   s = 8'd41;
            6'd16:   s = 8'd50;
            6'd17:   s = 8'd60;
            6'd18:   s = 8'd69;
            6'd19:   s = 8'd79;
            6'd20:   s = 8'd85;
            6'd21:   s = 8'd79;
            6'd22:   s = 8'd69;
            6'd23:   s = 8'd60;
            6'd24:   s = 8'd50;
            6'd25:   s = 8'd41;
            6'd26:   s = 8'd31;
            6'd27:   s = 8'd21;
            6'd28:   s = 8'd12;
            6'd29:   s = 8'd4;
            6'd30:   s = 8'd7;
            6'd31:   s = 8'd16;
            6'd32:   s = 8'd25;
            6'd33:   s = 8'd35;
            6'd34:   s = 8'd44;
            6'd35:   s = 8'd54;
            6'd36:   s = 8'd63;
            6'd37:   s = 8'd73;
            6'd38:   s = 8'd83;
            6'd39:   s = 8'd92;
            default: s = 8'd102;
        endcase
        return s;
    endfunction

endpackage

### src/safg_in_if.sv
// Input channel: one SNP probe item per handshake.
interface safg_in_if #(
    parameter int FRAC_BITS   = safg_pkg::FRAC_BITS_DEF,
    parameter int SIGNAL_BITS = safg_pkg::SIGNAL_BITS_DEF
);
    logic                   valid;
    logic                   ready;
    logic [FRAC_BITS:0]     beta;
    logic                   beta_valid;
    logic [1:0]             probe_kind;
    logic                   has_rs_id;
    logic [1:0]             in_band_color;
    logic [SIGNAL_BITS-1:0] meth_green;
    logic [SIGNAL_BITS-1:0] unmeth_green;
    logic [SIGNAL_BITS-1:0] meth_red;
    logic [SIGNAL_BITS-1:0] unmeth_red;
    logic                   signals_valid;

    modport source (
        output valid, beta, beta_valid, probe_kind, has_rs_id, in_band_color,
               meth_green, unmeth_green, meth_red, unmeth_red, signals_valid,
        input  ready
    );
    modport sink (
        input  valid, beta, beta_valid, probe_kind, has_rs_id, in_band_color,
               meth_green, unmeth_green, meth_red, unmeth_red, signals_valid,
        output ready
    );
endinterface

### src/safg_out_if.sv
// Output channel: one genotype result item per handshake.
interface safg_out_if #(
    parameter int FRAC_BITS = safg_pkg::FRAC_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic                         site_kept;
    logic [1:0]                   genotype;
    logic [safg_pkg::SCORE_W-1:0] score;
    logic                         pass_flag;
    logic [FRAC_BITS:0]           variant_fraction;

    modport source (
        output valid, site_kept, genotype, score, pass_flag, variant_fraction,
        input  ready
    );
    modport sink (
        input  valid, site_kept, genotype, score, pass_flag, variant_fraction,
        output ready
    );
endinterface

### src/safg_cfg_if.sv
// Configuration write channel: register index and write data.
interface safg_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [safg_pkg::CFG_IDX_W-1:0]  index;
    logic [safg_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

### src/safg_div_pipe.sv
// Pipelined restoring divider: one quotient bit per stage, numerator <= denominator.
module safg_div_pipe #(
    parameter int NUM_W = 17,
    parameter int DEN_W = 18,
    parameter int Q_W   = 17
) (
    input  logic             clk,
    input  logic             en,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic [Q_W-1:0]   quo
);

    localparam int R_W = DEN_W + 1;

    logic [DEN_W-1:0] rem_reg [Q_W];
    logic [DEN_W-1:0] den_reg [Q_W];
    logic [Q_W-1:0]   quo_reg [Q_W];

    for (genvar j = 0; j < Q_W; j++) begin : g_step
        logic [R_W-1:0]   rem_in;
        logic [R_W-1:0]   den_ext;
        logic [R_W-1:0]   diff;
        logic             ge;
        logic [DEN_W-1:0] rem_next;
        logic [Q_W-1:0]   quo_next;
        logic [DEN_W-1:0] den_next;

        if (j == 0) begin : g_first
            assign rem_in   = R_W'(num);
            assign den_next = den;
            assign quo_next = {{(Q_W-1){1'b0}}, ge};
        end
        else begin : g_rest
            assign rem_in   = {rem_reg[j-1], 1'b0};
            assign den_next = den_reg[j-1];
            assign quo_next = {quo_reg[j-1][Q_W-2:0], ge};
        end

        assign den_ext  = {1'b0, den_next};
        assign ge       = (rem_in >= den_ext);
        assign diff     = rem_in - den_ext;
        assign rem_next = ge ? diff[DEN_W-1:0] : rem_in[DEN_W-1:0];

        always_ff @(posedge clk) begin
            if (en) begin
                rem_reg[j] <= rem_next;
                den_reg[j] <= den_next;
                quo_reg[j] <= quo_next;
            end
        end
    end

    assign quo = quo_reg[Q_W-1];

endmodule

### src/snp_allele_fraction_genotyper.sv
// Top level of the SNP allele fraction genotyper pipeline.
//
// Usage:
//   in_ch  carries one SNP probe item per valid/ready handshake: beta, probe kind,
//          color and the four raw bead intensities.
//   out_ch returns exactly one result item per probe, in order: kept flag,
//          genotype, score, pass flag and the variant fraction.
//   cfg    writes rs_filter (index 0) and pass_threshold (index 1); always
//          ready. Write only while the pipeline is empty.
// Timing:
//   FRAC_BITS+4 register stages (20 at the defaults): decode, one stage per
//   quotient bit of the out-of-band divider, bead count, table lookup. One item per
//   cycle is taken while out_ch keeps ready high.
// Stall:
//   All stages advance together whenever the last stage is empty or being taken;
//   otherwise everything holds and in_ch.ready drops. Nothing is lost or repeated.
// Reset:
//   rst_n clears all stage valid bits and loads the register reset values
//   (rs_filter 0, pass_threshold 20).
module snp_allele_fraction_genotyper #(
    parameter int FRAC_BITS   = safg_pkg::FRAC_BITS_DEF,
    parameter int BEAD_COUNT  = safg_pkg::BEAD_COUNT_DEF,
    parameter int SIGNAL_BITS = safg_pkg::SIGNAL_BITS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    safg_in_if.sink      in_ch,
    safg_out_if.source   out_ch,
    safg_cfg_if.sink     cfg
);

    localparam int VAF_W  = FRAC_BITS + 1;
    localparam int NUM_W  = SIGNAL_BITS + 1;
    localparam int DEN_W  = SIGNAL_BITS + 2;
    localparam int DIV_N  = FRAC_BITS + 1;
    localparam int PROD_W = FRAC_BITS + 9;
    localparam int KR_W   = 8;
    localparam logic [VAF_W-1:0]  ONE_Q  = VAF_W'(1) << FRAC_BITS;
    localparam logic [PROD_W-1:0] HALF_Q = PROD_W'(1) << (FRAC_BITS - 1);

    // Configuration registers
    logic                         rs_filter_reg;
    logic [safg_pkg::SCORE_W-1:0] pass_threshold_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            rs_filter_reg      <= 1'b0;
            pass_threshold_reg <= safg_pkg::PASS_THRESHOLD_RST;
        end
        else if (cfg.valid) begin
            case (cfg.index)
                safg_pkg::CFG_RS_FILTER:      rs_filter_reg      <= cfg.data[0];
                safg_pkg::CFG_PASS_THRESHOLD: pass_threshold_reg <= cfg.data;
                default: ;
            endcase
        end
    end

    // Global advance: move every stage when the output slot is free or drained.
    logic en;
    logic out_valid_reg;

    assign en          = !out_valid_reg || out_ch.ready;
    assign in_ch.ready = en;

    // ---------------- Stage A: decode, saturate beta, form oob and total ----------
    logic             a_valid_reg;
    logic             a_ok_reg;
    logic             a_div_reg;
    logic [VAF_W-1:0] a_vaf_reg;
    logic [NUM_W-1:0] a_oob_reg;
    logic [DEN_W-1:0] a_total_reg;

    logic             a_ok_next;
    logic             a_div_next;
    logic [VAF_W-1:0] a_vaf_next;
    logic [NUM_W-1:0] a_oob_next;
    logic [DEN_W-1:0] a_total_next;
    logic [VAF_W-1:0] beta_sat;
    logic [NUM_W-1:0] green_sum;
    logic [NUM_W-1:0] red_sum;
    logic [NUM_W-1:0] oob_raw;
    logic             color_ok;

    always_comb begin
        beta_sat  = (in_ch.beta > ONE_Q) ? ONE_Q : in_ch.beta;
        green_sum = NUM_W'(in_ch.meth_green) + NUM_W'(in_ch.unmeth_green);
        red_sum   = NUM_W'(in_ch.meth_red) + NUM_W'(in_ch.unmeth_red);
        color_ok  = (in_ch.in_band_color == safg_pkg::COLOR_GREEN)
                 || (in_ch.in_band_color == safg_pkg::COLOR_RED);
        // Out-of-band channel is the one the probe does not fluoresce in.
        oob_raw   = (in_ch.in_band_color == safg_pkg::COLOR_GREEN) ? red_sum : green_sum;
        a_oob_next   = (oob_raw == '0) ? NUM_W'(1) : oob_raw;
        a_total_next = DEN_W'(green_sum) + DEN_W'(red_sum);
        if (a_total_next < DEN_W'(2)) begin
            a_total_next = DEN_W'(2);
        end
        a_div_next = (in_ch.probe_kind == safg_pkg::KIND_CSW);
        a_vaf_next = (in_ch.probe_kind == safg_pkg::KIND_ALT) ? (ONE_Q - beta_sat) : beta_sat;
        if (a_div_next) begin
            a_ok_next = !(rs_filter_reg && !in_ch.has_rs_id)
                     && in_ch.signals_valid && color_ok;
        end
        else begin
            a_ok_next = in_ch.beta_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            a_valid_reg <= 1'b0;
        end
        else if (en) begin
            a_valid_reg <= in_ch.valid;
        end
    end

    always_ff @(posedge clk) begin
        if (en) begin
            a_ok_reg    <= a_ok_next;
            a_div_reg   <= a_div_next;
            a_vaf_reg   <= a_vaf_next;
            a_oob_reg   <= a_oob_next;
            a_total_reg <= a_total_next;
        end
    end

    // ---------------- Divider stages, sideband delayed alongside ----------------
    logic [VAF_W-1:0] quo;

    safg_div_pipe #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W),
        .Q_W   (DIV_N)
    ) u_div (
        .clk (clk),
        .en  (en),
        .num (a_oob_reg),
        .den (a_total_reg),
        .quo (quo)
    );

    logic             d_valid_reg [DIV_N];
    logic             d_ok_reg    [DIV_N];
    logic             d_div_reg   [DIV_N];
    logic [VAF_W-1:0] d_vaf_reg   [DIV_N];

    for (genvar j = 0; j < DIV_N; j++) begin : g_side
        logic             valid_in;
        logic             ok_in;
        logic             div_in;
        logic [VAF_W-1:0] vaf_in;

        if (j == 0) begin : g_first
            assign valid_in = a_valid_reg;
            assign ok_in    = a_ok_reg;
            assign div_in   = a_div_reg;
            assign vaf_in   = a_vaf_reg;
        end
        else begin : g_rest
            assign valid_in = d_valid_reg[j-1];
            assign ok_in    = d_ok_reg[j-1];
            assign div_in   = d_div_reg[j-1];
            assign vaf_in   = d_vaf_reg[j-1];
        end

        always_ff @(posedge clk or negedge rst_n) begin
            if (!rst_n) begin
                d_valid_reg[j] <= 1'b0;
            end
            else if (en) begin
                d_valid_reg[j] <= valid_in;
            end
        end

        always_ff @(posedge clk) begin
            if (en) begin
                d_ok_reg[j]  <= ok_in;
                d_div_reg[j] <= div_in;
                d_vaf_reg[j] <= vaf_in;
            end
        end
    end

    // ---------------- Stage K: select fraction, round to bead count ----------------
    logic                         k_valid_reg;
    logic                         k_ok_reg;
    logic [VAF_W-1:0]             k_vaf_reg;
    logic [safg_pkg::K_W-1:0]     k_idx_reg;

    logic [VAF_W-1:0]             k_vaf_next;
    logic [PROD_W-1:0]            k_prod;
    logic [KR_W-1:0]              k_round;
    logic [safg_pkg::K_W-1:0]     k_idx_next;

    always_comb begin
        if (d_div_reg[DIV_N-1]) begin
            k_vaf_next = (quo > ONE_Q) ? ONE_Q : quo;
        end
        else begin
            k_vaf_next = d_vaf_reg[DIV_N-1];
        end
        k_prod  = PROD_W'(k_vaf_next) * PROD_W'(BEAD_COUNT) + HALF_Q;
        k_round = k_prod[FRAC_BITS +: KR_W];
        // Hold the last table row for counts past the table end.
        if (k_round > KR_W'(safg_pkg::TABLE_LAST)) begin
            k_idx_next = safg_pkg::K_W'(safg_pkg::TABLE_LAST);
        end
        else begin
            k_idx_next = k_round[safg_pkg::K_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            k_valid_reg <= 1'b0;
        end
        else if (en) begin
            k_valid_reg <= d_valid_reg[DIV_N-1];
        end
    end

    always_ff @(posedge clk) begin
        if (en) begin
            k_ok_reg  <= d_ok_reg[DIV_N-1];
            k_vaf_reg <= k_vaf_next;
            k_idx_reg <= k_idx_next;
        end
    end

    // ---------------- Output stage: table lookup, pass test, drop zeroing ----------
    logic                         site_kept_reg;
    logic [1:0]                   genotype_reg;
    logic [safg_pkg::SCORE_W-1:0] score_reg;
    logic                         pass_flag_reg;
    logic [VAF_W-1:0]             vaf_out_reg;

    logic [safg_pkg::SCORE_W-1:0] score_next;

    assign score_next = safg_pkg::score_lookup(k_idx_reg);

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end
        else if (en) begin
            out_valid_reg <= k_valid_reg;
        end
    end

    always_ff @(posedge clk) begin
        if (en) begin
            site_kept_reg <= k_ok_reg;
            if (k_ok_reg) begin
                genotype_reg  <= safg_pkg::gt_lookup(k_idx_reg);
                score_reg     <= score_next;
                pass_flag_reg <= (score_next > pass_threshold_reg);
                vaf_out_reg   <= k_vaf_reg;
            end
            else begin
                // Dropped site: clear every result field.
                genotype_reg  <= safg_pkg::GT_HOM_REF;
                score_reg     <= '0;
                pass_flag_reg <= 1'b0;
                vaf_out_reg   <= '0;
            end
        end
    end

    assign out_ch.valid            = out_valid_reg;
    assign out_ch.site_kept        = site_kept_reg;
    assign out_ch.genotype         = genotype_reg;
    assign out_ch.score            = score_reg;
    assign out_ch.pass_flag        = pass_flag_reg;
    assign out_ch.variant_fraction = vaf_out_reg;

endmodule
